[design/stp_pkg.sv]
// Shared types, codes and constants of the script token parser.
package stp_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] MAX_DIRECT_PUSH   = 8'd75;
  localparam logic [7:0] PUSH_ONE_BYTE_LEN = 8'd76;
  localparam logic [7:0] PUSH_TWO_BYTE_LEN = 8'd77;
  localparam logic [7:0] VARINT_TWO        = 8'hFD;
  localparam logic [7:0] VARINT_FOUR       = 8'hFE;

  localparam logic [2:0] PH_VARINT_FIRST = 3'd0;
  localparam logic [2:0] PH_VARINT_MORE  = 3'd1;
  localparam logic [2:0] PH_TOKEN        = 3'd2;
  localparam logic [2:0] PH_PUSH_LEN     = 3'd3;
  localparam logic [2:0] PH_PUSH_DATA    = 3'd4;

  localparam logic [2:0] ROLE_VARINT   = 3'd0;
  localparam logic [2:0] ROLE_OPCODE   = 3'd1;
  localparam logic [2:0] ROLE_PREFIX   = 3'd2;
  localparam logic [2:0] ROLE_LEN_BYTE = 3'd3;
  localparam logic [2:0] ROLE_DATA     = 3'd4;

  localparam logic [1:0] BODY_DIRECT = 2'd0;
  localparam logic [1:0] BODY_PUSH1  = 2'd1;
  localparam logic [1:0] BODY_PUSH2  = 2'd2;
  localparam logic [1:0] BODY_OPCODE = 2'd3;

  localparam logic [1:0] VI_SHORT = 2'd0;
  localparam logic [1:0] VI_TWO   = 2'd1;
  localparam logic [1:0] VI_FOUR  = 2'd2;
  localparam logic [1:0] VI_EIGHT = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic [1:0] body_cls;
    logic [1:0] vi_cls;
  } stp_entry_t;

endpackage

[design/stp_if.sv]
// Valid/ready channel interfaces for the parser's input and result items.
interface stp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface stp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_role;
  logic        token_start;
  logic        token_end;
  logic        is_opcode;
  logic [7:0]  op_value;
  logic [15:0] push_size;
  logic [31:0] script_length;
  logic        script_end;

  modport source (output valid, output byte_role, output token_start, output token_end,
                  output is_opcode, output op_value, output push_size,
                  output script_length, output script_end, input ready);
  modport sink   (input valid, input byte_role, input token_start, input token_end,
                  input is_opcode, input op_value, input push_size,
                  input script_length, input script_end, output ready);
endinterface

[design/stp_front.sv]
// Front end: accepts input bytes and classifies them for the queue.
module stp_front (
  stp_in_if.sink                in_if,
  input  logic                  q_full,
  output logic                  push,
  output stp_pkg::stp_entry_t   entry
);

  logic [7:0] b;

  assign b        = in_if.in_byte;
  assign in_if.ready = !q_full;
  assign push     = in_if.valid && !q_full;

  always_comb begin
    entry.in_byte = b;
    if (b >= 8'd1 && b <= stp_pkg::MAX_DIRECT_PUSH) begin
      entry.body_cls = stp_pkg::BODY_DIRECT;
    end else if (b == stp_pkg::PUSH_ONE_BYTE_LEN) begin
      entry.body_cls = stp_pkg::BODY_PUSH1;
    end else if (b == stp_pkg::PUSH_TWO_BYTE_LEN) begin
      entry.body_cls = stp_pkg::BODY_PUSH2;
    end else begin
      entry.body_cls = stp_pkg::BODY_OPCODE;
    end
    if (b < stp_pkg::VARINT_TWO) begin
      entry.vi_cls = stp_pkg::VI_SHORT;
    end else if (b == stp_pkg::VARINT_TWO) begin
      entry.vi_cls = stp_pkg::VI_TWO;
    end else if (b == stp_pkg::VARINT_FOUR) begin
      entry.vi_cls = stp_pkg::VI_FOUR;
    end else begin
      entry.vi_cls = stp_pkg::VI_EIGHT;
    end
  end

endmodule

[design/stp_queue.sv]
// Short FIFO between the classifying front end and the executing back end.
module stp_queue #(
  parameter int DEPTH = stp_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  stp_pkg::stp_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output stp_pkg::stp_entry_t head_entry
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  stp_pkg::stp_entry_t slots_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == FULL_COUNT);
  assign head_valid = (count_r != '0);
  assign head_entry = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[design/stp_back.sv]
// Back end: tokenizer state machine and the registered result stage.
module stp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  stp_pkg::stp_entry_t head_entry,
  output logic                pop,
  stp_out_if.source           out_if
);

  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  vleft_r, vleft_nxt;
  logic [2:0]  vpos_r, vpos_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] cons_r, cons_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [1:0]  pleft_r, pleft_nxt;
  logic [15:0] dleft_r, dleft_nxt;
  logic        two_r, two_nxt;

  logic        ovalid_r;
  logic [2:0]  role_r, o_role;
  logic        start_r, o_start;
  logic        end_r, o_end;
  logic        isop_r, o_isop;
  logic [7:0]  opv_r, o_opv;
  logic [15:0] psize_r, o_psize;
  logic [31:0] slen_r, o_slen;
  logic        send_r, o_send;

  logic [7:0]  b;
  logic [31:0] cons_inc;
  logic [31:0] vacc;
  logic [3:0]  vleft_dec;
  logic [15:0] plen_new;
  logic [1:0]  pleft_new;
  logic [15:0] dleft_dec;
  logic        fin_varint;
  logic        fin_tok;
  logic        clear;

  assign b        = head_entry.in_byte;
  assign pop      = head_valid && (!ovalid_r || out_if.ready);
  assign cons_inc = (cons_r == '1) ? cons_r : cons_r + 32'd1;

  always_comb begin
    phase_nxt = phase_r;
    vleft_nxt = vleft_r;
    vpos_nxt  = vpos_r;
    len_nxt   = len_r;
    cons_nxt  = cons_r;
    plen_nxt  = plen_r;
    pleft_nxt = pleft_r;
    dleft_nxt = dleft_r;
    two_nxt   = two_r;
    o_role    = stp_pkg::ROLE_VARINT;
    o_start   = 1'b0;
    o_end     = 1'b0;
    o_isop    = 1'b0;
    o_opv     = '0;
    o_psize   = '0;
    o_slen    = '0;
    o_send    = 1'b0;
    fin_varint = 1'b0;
    fin_tok   = 1'b0;
    clear     = 1'b0;
    vacc      = '0;
    vleft_dec = (vleft_r != '0) ? vleft_r - 4'd1 : vleft_r;
    dleft_dec = (dleft_r != '0) ? dleft_r - 16'd1 : dleft_r;
    plen_new  = plen_r;
    pleft_new = pleft_r;

    case (phase_r)
      stp_pkg::PH_VARINT_MORE: begin
        vacc = len_r;
        if (!vpos_r[2]) begin
          vacc = len_r | ({24'd0, b} << {vpos_r[1:0], 3'b000});
        end
        len_nxt   = vacc;
        vpos_nxt  = vpos_r + 3'd1;
        vleft_nxt = vleft_dec;
        fin_varint = (vleft_dec == '0);
      end
      stp_pkg::PH_TOKEN: begin
        o_slen   = len_r;
        o_start  = 1'b1;
        cons_nxt = cons_inc;
        case (head_entry.body_cls)
          stp_pkg::BODY_DIRECT: begin
            o_role    = stp_pkg::ROLE_PREFIX;
            o_psize   = {8'd0, b};
            plen_nxt  = {8'd0, b};
            dleft_nxt = {8'd0, b};
            phase_nxt = stp_pkg::PH_PUSH_DATA;
          end
          stp_pkg::BODY_PUSH1, stp_pkg::BODY_PUSH2: begin
            o_role    = stp_pkg::ROLE_PREFIX;
            plen_nxt  = '0;
            two_nxt   = (head_entry.body_cls == stp_pkg::BODY_PUSH2);
            pleft_nxt = (head_entry.body_cls == stp_pkg::BODY_PUSH2) ? 2'd2 : 2'd1;
            phase_nxt = stp_pkg::PH_PUSH_LEN;
          end
          default: begin
            o_role  = stp_pkg::ROLE_OPCODE;
            o_isop  = 1'b1;
            o_opv   = b;
            fin_tok = 1'b1;
          end
        endcase
      end
      stp_pkg::PH_PUSH_LEN: begin
        o_slen   = len_r;
        o_role   = stp_pkg::ROLE_LEN_BYTE;
        cons_nxt = cons_inc;
        if (two_r && pleft_r == 2'd2) begin
          plen_new  = {8'd0, b};
          pleft_new = 2'd1;
        end else if (two_r) begin
          plen_new  = {b, plen_r[7:0]};
          pleft_new = 2'd0;
        end else begin
          plen_new  = {8'd0, b};
          pleft_new = 2'd0;
        end
        plen_nxt  = plen_new;
        pleft_nxt = pleft_new;
        if (pleft_new == 2'd0) begin
          o_psize = plen_new;
          if (plen_new == '0) begin
            fin_tok = 1'b1;
          end else begin
            dleft_nxt = plen_new;
            phase_nxt = stp_pkg::PH_PUSH_DATA;
          end
        end
      end
      stp_pkg::PH_PUSH_DATA: begin
        o_slen    = len_r;
        o_role    = stp_pkg::ROLE_DATA;
        o_psize   = plen_r;
        cons_nxt  = cons_inc;
        dleft_nxt = dleft_dec;
        fin_tok   = (dleft_dec == '0);
      end
      default: begin
        if (head_entry.vi_cls == stp_pkg::VI_SHORT) begin
          vacc       = {24'd0, b};
          len_nxt    = vacc;
          fin_varint = 1'b1;
        end else begin
          len_nxt   = '0;
          vpos_nxt  = '0;
          case (head_entry.vi_cls)
            stp_pkg::VI_TWO:  vleft_nxt = 4'd2;
            stp_pkg::VI_FOUR: vleft_nxt = 4'd4;
            default:          vleft_nxt = 4'd8;
          endcase
          phase_nxt = stp_pkg::PH_VARINT_MORE;
        end
      end
    endcase

    if (fin_varint) begin
      o_slen    = vacc;
      cons_nxt  = '0;
      vleft_nxt = '0;
      vpos_nxt  = '0;
      if (vacc == '0) begin
        o_send = 1'b1;
        clear  = 1'b1;
      end else begin
        phase_nxt = stp_pkg::PH_TOKEN;
      end
    end

    if (fin_tok) begin
      o_end = 1'b1;
      if (cons_inc >= len_r) begin
        o_send = 1'b1;
        clear  = 1'b1;
      end else begin
        phase_nxt = stp_pkg::PH_TOKEN;
        pleft_nxt = '0;
        dleft_nxt = '0;
      end
    end

    if (clear) begin
      phase_nxt = stp_pkg::PH_VARINT_FIRST;
      vleft_nxt = '0;
      vpos_nxt  = '0;
      len_nxt   = '0;
      cons_nxt  = '0;
      plen_nxt  = '0;
      pleft_nxt = '0;
      dleft_nxt = '0;
      two_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= stp_pkg::PH_VARINT_FIRST;
      vleft_r  <= '0;
      vpos_r   <= '0;
      len_r    <= '0;
      cons_r   <= '0;
      plen_r   <= '0;
      pleft_r  <= '0;
      dleft_r  <= '0;
      two_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r <= phase_nxt;
        vleft_r <= vleft_nxt;
        vpos_r  <= vpos_nxt;
        len_r   <= len_nxt;
        cons_r  <= cons_nxt;
        plen_r  <= plen_nxt;
        pleft_r <= pleft_nxt;
        dleft_r <= dleft_nxt;
        two_r   <= two_nxt;
      end
      if (pop) begin
        ovalid_r <= 1'b1;
      end else if (out_if.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      role_r  <= o_role;
      start_r <= o_start;
      end_r   <= o_end;
      isop_r  <= o_isop;
      opv_r   <= o_opv;
      psize_r <= o_psize;
      slen_r  <= o_slen;
      send_r  <= o_send;
    end
  end

  assign out_if.valid         = ovalid_r;
  assign out_if.byte_role     = role_r;
  assign out_if.token_start   = start_r;
  assign out_if.token_end     = end_r;
  assign out_if.is_opcode     = isop_r;
  assign out_if.op_value      = opv_r;
  assign out_if.push_size     = psize_r;
  assign out_if.script_length = slen_r;
  assign out_if.script_end    = send_r;

endmodule

[design/script_token_parser_core.sv]
// Top level of the script token parser: front end, queue and back end.
// The parser takes one raw script byte per item and returns one result item per byte, so it
// runs at one byte per clock when the result side keeps up. An item passes the classifying
// front end into a short queue (QUEUE_DEPTH entries), is executed by the tokenizer state
// machine, and is loaded into the result register at the edge at which it leaves the queue.
// Each script opens with a compact-size length and ends on the byte that completes the last
// token, or on its length when that length is zero, after which the next byte is read as a
// new length. There is no configuration.
module script_token_parser_core #(
  parameter int QUEUE_DEPTH = stp_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  stp_in_if.sink    in_if,
  stp_out_if.source out_if
);

  stp_pkg::stp_entry_t front_entry;
  stp_pkg::stp_entry_t head_entry;
  logic                q_full;
  logic                q_push;
  logic                q_pop;
  logic                q_valid;

  stp_front u_front (
    .in_if  (in_if),
    .q_full (q_full),
    .push   (q_push),
    .entry  (front_entry)
  );

  stp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (head_entry)
  );

  stp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_entry (head_entry),
    .pop        (q_pop),
    .out_if     (out_if)
  );

endmodule

[design/stp_checker.sv]
// Port-level assertions for the script token parser and their bind.
module stp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  byte_role,
  input logic        token_start,
  input logic        token_end,
  input logic        is_opcode,
  input logic [15:0] push_size,
  input logic        script_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result item dropped while stalled.");

  a_end_on_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && script_end |-> token_end || byte_role == stp_pkg::ROLE_VARINT)
    else $error("Script ended on a byte that completes no token.");

  a_start_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && token_start |->
      byte_role == stp_pkg::ROLE_PREFIX || byte_role == stp_pkg::ROLE_OPCODE)
    else $error("Token started on a byte that is neither prefix nor opcode.");

  a_opcode_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_opcode |->
      token_start && token_end && byte_role == stp_pkg::ROLE_OPCODE)
    else $error("Opcode item is not a complete one-byte token.");

  a_data_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && byte_role == stp_pkg::ROLE_DATA |-> push_size != '0)
    else $error("Push data item without a push size.");

endmodule

bind script_token_parser_core stp_checker u_stp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .byte_role   (out_if.byte_role),
  .token_start (out_if.token_start),
  .token_end   (out_if.token_end),
  .is_opcode   (out_if.is_opcode),
  .push_size   (out_if.push_size),
  .script_end  (out_if.script_end)
);

[tb/sv/script_token_parser_core_tb.sv]
// Self-checking testbench for the script token parser: directed table, then random scripts.
module script_token_parser_core_tb;
  import stp_pkg::*;

  localparam logic [7:0] VARINT_EIGHT = 8'hFF;
  localparam int HOLD_CYCLES = 250;

  typedef struct packed {
    logic [2:0]  role;
    logic        tok_start;
    logic        tok_end;
    logic        is_op;
    logic [7:0]  op;
    logic [15:0] push_sz;
    logic [31:0] script_len;
    logic        script_end;
  } parse_result_t;

  typedef struct packed {
    logic [7:0]    b;
    logic          given;
    parse_result_t want;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [27] = '{
    '{8'h00, 1'b1, '{ROLE_VARINT, 1'b0, 1'b0, 1'b0, 8'h00, 16'd0, 32'd0, 1'b1}},
    '{8'h02, 1'b1, '{ROLE_VARINT, 1'b0, 1'b0, 1'b0, 8'h00, 16'd0, 32'd2, 1'b0}},
    '{8'h00, 1'b1, '{ROLE_OPCODE, 1'b1, 1'b1, 1'b1, 8'h00, 16'd0, 32'd2, 1'b0}},
    '{8'hFF, 1'b1, '{ROLE_OPCODE, 1'b1, 1'b1, 1'b1, 8'hFF, 16'd0, 32'd2, 1'b1}},
    '{8'hFD, 1'b1, '{ROLE_VARINT, 1'b0, 1'b0, 1'b0, 8'h00, 16'd0, 32'd0, 1'b0}},
    '{8'h05, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'hAB, 1'b0, '0},
    '{8'h4C, 1'b0, '0},
    '{8'h00, 1'b1, '{ROLE_LEN_BYTE, 1'b0, 1'b1, 1'b0, 8'h00, 16'd0, 32'd5, 1'b0}},
    '{8'h4D, 1'b0, '0},
    '{8'h02, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h11, 1'b0, '0},
    '{8'h22, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h02, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hAA, 1'b0, '0},
    '{8'hBB, 1'b0, '0},
    '{8'hCC, 1'b0, '0},
    '{8'hDD, 1'b0, '0},
    '{8'h4E, 1'b0, '0},
    '{8'h60, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  stp_in_if  in_ch ();
  stp_out_if out_ch ();

  script_token_parser_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  parse_result_t predicted_labels [$];
  int mismatch_count = 0;
  int bytes_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  logic [2:0]  p_phase;
  logic [3:0]  vi_left;
  int          vi_index;
  logic [31:0] decl_len;
  logic [31:0] body_count;
  logic [15:0] push_len;
  logic [1:0]  len_bytes_left;
  logic [15:0] data_left;
  logic        long_len_field;

  function automatic void clear_parser();
    p_phase        = PH_VARINT_FIRST;
    vi_left        = '0;
    vi_index       = 0;
    decl_len       = '0;
    body_count     = '0;
    push_len       = '0;
    len_bytes_left = '0;
    data_left      = '0;
    long_len_field = 1'b0;
  endfunction

  function automatic void count_body();
    if (body_count != 32'hFFFF_FFFF) body_count++;
  endfunction

  function automatic void close_length(inout parse_result_t r);
    r.script_len = decl_len;
    body_count   = '0;
    vi_left      = '0;
    vi_index     = 0;
    if (decl_len == 0) begin
      r.script_end = 1'b1;
      clear_parser();
    end else begin
      p_phase = PH_TOKEN;
    end
  endfunction

  function automatic void close_token(inout parse_result_t r);
    r.tok_end = 1'b1;
    if (body_count >= decl_len) begin
      r.script_end = 1'b1;
      clear_parser();
    end else begin
      p_phase        = PH_TOKEN;
      len_bytes_left = '0;
      data_left      = '0;
    end
  endfunction

  function automatic parse_result_t label_byte(logic [7:0] b);
    parse_result_t r;
    r = '0;
    case (p_phase)
      PH_VARINT_MORE: begin
        r.role = ROLE_VARINT;
        if (vi_index < 4) decl_len = decl_len | (32'(b) << (8 * vi_index));
        vi_index++;
        if (vi_left != 0) vi_left--;
        if (vi_left == 0) close_length(r);
      end
      PH_TOKEN: begin
        r.script_len = decl_len;
        r.tok_start  = 1'b1;
        count_body();
        if (b >= 8'd1 && b <= MAX_DIRECT_PUSH) begin
          r.role    = ROLE_PREFIX;
          r.push_sz = 16'(b);
          push_len  = 16'(b);
          data_left = 16'(b);
          p_phase   = PH_PUSH_DATA;
        end else if (b == PUSH_ONE_BYTE_LEN || b == PUSH_TWO_BYTE_LEN) begin
          r.role         = ROLE_PREFIX;
          push_len       = '0;
          long_len_field = (b == PUSH_TWO_BYTE_LEN);
          len_bytes_left = long_len_field ? 2'd2 : 2'd1;
          p_phase        = PH_PUSH_LEN;
        end else begin
          r.role  = ROLE_OPCODE;
          r.is_op = 1'b1;
          r.op    = b;
          close_token(r);
        end
      end
      PH_PUSH_LEN: begin
        r.script_len = decl_len;
        r.role       = ROLE_LEN_BYTE;
        count_body();
        if (long_len_field && len_bytes_left == 2'd2) begin
          push_len       = 16'(b);
          len_bytes_left = 2'd1;
        end else if (long_len_field) begin
          push_len       = {b, push_len[7:0]};
          len_bytes_left = 2'd0;
        end else begin
          push_len       = 16'(b);
          len_bytes_left = 2'd0;
        end
        if (len_bytes_left == 0) begin
          r.push_sz = push_len;
          if (push_len == 0) begin
            close_token(r);
          end else begin
            data_left = push_len;
            p_phase   = PH_PUSH_DATA;
          end
        end
      end
      PH_PUSH_DATA: begin
        r.script_len = decl_len;
        r.role       = ROLE_DATA;
        r.push_sz    = push_len;
        count_body();
        if (data_left != 0) data_left--;
        if (data_left == 0) close_token(r);
      end
      default: begin
        r.role = ROLE_VARINT;
        if (b < VARINT_TWO) begin
          decl_len = 32'(b);
          close_length(r);
        end else begin
          decl_len = '0;
          vi_index = 0;
          vi_left  = (b == VARINT_TWO) ? 4'd2 : ((b == VARINT_FOUR) ? 4'd4 : 4'd8);
          p_phase  = PH_VARINT_MORE;
        end
      end
    endcase
    return r;
  endfunction

  function automatic string show(parse_result_t r);
    return $sformatf("role=%0d start=%0b end=%0b op=%0b/%02h push=%0d len=%0d send=%0b",
                     r.role, r.tok_start, r.tok_end, r.is_op, r.op, r.push_sz,
                     r.script_len, r.script_end);
  endfunction

  function automatic void flag_error(string what, parse_result_t want, parse_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s: expected %s, got %s", what, show(want), show(got));
  endfunction

  function automatic void check_label();
    parse_result_t got;
    parse_result_t want;
    got = '{out_ch.byte_role, out_ch.token_start, out_ch.token_end, out_ch.is_opcode,
            out_ch.op_value, out_ch.push_size, out_ch.script_length, out_ch.script_end};
    if (predicted_labels.size() == 0) begin
      flag_error("Result item with no byte pending", '0, got);
    end else begin
      want = predicted_labels.pop_front();
      if (got.role !== want.role || got.tok_start !== want.tok_start ||
          got.tok_end !== want.tok_end || got.is_op !== want.is_op ||
          got.op !== want.op || got.push_sz !== want.push_sz ||
          got.script_len !== want.script_len || got.script_end !== want.script_end)
        flag_error("Label mismatch", want, got);
    end
  endfunction

  task automatic send_byte(logic [7:0] b, logic given = 1'b0, parse_result_t want = '0);
    parse_result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    pred = label_byte(b);
    predicted_labels.insert(predicted_labels.size(), given ? want : pred);
    bytes_sent++;
  endtask

  task automatic send_script();
    logic [7:0] body [$];
    int kind;
    int n;
    int decl;
    int form;
    repeat ($urandom_range(0, 5)) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3 || kind == 9) begin
        if ($urandom_range(0, 3) == 0) body.insert(body.size(), 8'h00);
        else body.insert(body.size(), 8'($urandom_range(int'(PUSH_TWO_BYTE_LEN) + 1, 255)));
      end else if (kind <= 6) begin
        n = ($urandom_range(0, 19) == 0) ? int'(MAX_DIRECT_PUSH) : $urandom_range(1, 8);
        body.insert(body.size(), 8'(n));
        repeat (n) body.insert(body.size(), 8'($urandom));
      end else if (kind == 7) begin
        n = ($urandom_range(0, 29) == 0) ? $urandom_range(76, 255) : $urandom_range(0, 6);
        body.insert(body.size(), PUSH_ONE_BYTE_LEN);
        body.insert(body.size(), 8'(n));
        repeat (n) body.insert(body.size(), 8'($urandom));
      end else begin
        n = ($urandom_range(0, 29) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 6);
        body.insert(body.size(), PUSH_TWO_BYTE_LEN);
        body.insert(body.size(), 8'(n));
        body.insert(body.size(), 8'(n >> 8));
        repeat (n) body.insert(body.size(), 8'($urandom));
      end
    end

    // Some scripts declare a length that disagrees with the tokens that follow.
    decl = body.size();
    if ($urandom_range(0, 6) == 0) decl = decl + $urandom_range(0, 6) - 3;
    if (decl < 0) decl = 0;

    form = $urandom_range(0, 9);
    if (form <= 5 && decl < int'(VARINT_TWO)) begin
      send_byte(8'(decl));
    end else if (form <= 7) begin
      send_byte(VARINT_TWO);
      for (int i = 0; i < 2; i++) send_byte(8'(decl >> (8 * i)));
    end else if (form == 8) begin
      send_byte(VARINT_FOUR);
      for (int i = 0; i < 4; i++) send_byte(8'(decl >> (8 * i)));
    end else begin
      send_byte(VARINT_EIGHT);
      for (int i = 0; i < 4; i++) send_byte(8'(decl >> (8 * i)));
      repeat (4) send_byte(8'($urandom));
    end

    foreach (body[i])
      if (p_phase != PH_VARINT_FIRST) send_byte(body[i]);

    if ($urandom_range(0, 11) == 0)
      repeat ($urandom_range(1, 3))
        if (p_phase == PH_TOKEN || p_phase == PH_PUSH_DATA) send_byte(8'($urandom));

    // Close whatever is still open so that the next script starts on a length.
    while (p_phase != PH_VARINT_FIRST) begin
      case (p_phase)
        PH_TOKEN:     send_byte(8'($urandom_range(int'(PUSH_TWO_BYTE_LEN) + 1, 255)));
        PH_PUSH_DATA: send_byte(8'($urandom));
        default:      send_byte(8'h00);
      endcase
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) check_label();
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= 8'h00;
    clear_parser();
    wait (rst_n);
    @(posedge clk);

    send_idle_pct = 33;
    recv_idle_pct = 50;
    foreach (DIRECTED_ROWS[i])
      send_byte(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].given, DIRECTED_ROWS[i].want);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 33 : ((ph == 1) ? 50 : 0);
      recv_idle_pct = (ph == 0) ? 50 : ((ph == 1) ? 33 : 0);
      if (ph == 2) hold_req = 1'b1;
      while (bytes_sent < 27 + 317 * (ph + 1)) send_script();
    end
    in_ch.valid <= 1'b0;

    while (predicted_labels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
design/stp_pkg.sv
design/stp_if.sv
design/stp_front.sv
design/stp_queue.sv
design/stp_back.sv
design/script_token_parser_core.sv
design/stp_checker.sv
tb/sv/script_token_parser_core_tb.sv
